// ===== hdl/vrmp_pkg.sv =====
// shared types and constants for the motion profile block
package vrmp_pkg;

    localparam int DUR_W = 16;
    localparam int REQ_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK     = 2'd0,
        REQ_RETARGET = 2'd1,
        REQ_JUMP     = 2'd2
    } vrmp_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } vrmp_unit_status_t;

endpackage

// ===== hdl/vrmp_serial_mul.sv =====
// unsigned shift-add multiplier, one multiplier bit per cycle
module vrmp_serial_mul
    import vrmp_pkg::*;
#(
    parameter int A_W = 24,
    parameter int B_W = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output vrmp_unit_status_t    status,
    output logic [A_W+B_W-1:0]   prod
);

    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic [A_W-1:0]   a_reg, a_next;
    logic [A_W-1:0]   acc_reg, acc_next;
    logic [B_W-1:0]   mq_reg, mq_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [A_W:0]     sum;

    assign sum = {1'b0, acc_reg} + (mq_reg[0] ? {1'b0, a_reg} : {(A_W+1){1'b0}});

    always_comb begin
        a_next    = a_reg;
        acc_next  = acc_reg;
        mq_next   = mq_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = a;
            acc_next  = '0;
            mq_next   = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = sum[A_W:1];
            mq_next  = {sum[0], mq_reg[B_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(B_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg   <= a_next;
        acc_reg <= acc_next;
        mq_reg  <= mq_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign prod        = {acc_reg, mq_reg};

endmodule

// ===== hdl/vrmp_serial_div.sv =====
// restoring divider, one quotient bit per cycle
module vrmp_serial_div
    import vrmp_pkg::*;
#(
    parameter int N_W = 26,
    parameter int D_W = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [N_W-1:0]    dividend,
    input  logic [D_W-1:0]    divisor,
    output vrmp_unit_status_t status,
    output logic [N_W-1:0]    quotient
);

    localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

    logic [N_W-1:0]   qd_reg, qd_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W-1:0]   dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             ge;

    assign trial = {rem_reg, qd_reg[N_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        qd_next   = qd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            qd_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[D_W-1:0] : trial[D_W-1:0];
            qd_next  = {qd_reg[N_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(N_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        qd_reg  <= qd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = qd_reg;

endmodule

// ===== hdl/value_relaxation_motion_profile.sv =====
// top level of the accelerate-then-brake motion profile
//
// channel  dir  tdata                                    tuser
// s_       in   new_value, duration_ticks                req_type
// m_       out  current_out                              in_progress
//
// one word in at a time; s_tready is high while no word is in work
// tick at target, jump, unused kind, zero-duration retarget: IDLE, EXEC, DONE
// moving tick: EXEC, TDIFF, then TMUL, waiting on the bit-serial square and product
// other retarget: EXEC, RSQ, then RDIV, waiting on the serial duration square and divider
// a finished word waits in the output register; the next input is taken meanwhile
// reset is synchronous; the block is ready in the first cycle after reset
module value_relaxation_motion_profile
    import vrmp_pkg::*;
#(
    parameter int VALUE_WIDTH = 24,
    parameter int FRAC_BITS   = 8,
    localparam int S_DATA_W   = ((VALUE_WIDTH + DUR_W + 7) / 8) * 8,
    localparam int M_DATA_W   = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // new_value, duration_ticks
    input  logic [REQ_W-1:0]    s_tuser,   // req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // current_out
    output logic                m_tuser    // in_progress
);

    localparam int W  = VALUE_WIDTH;
    localparam int TT_W = 2 * DUR_W;
    localparam logic [W-1:0] V_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] V_ONE = W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TDIFF,
        ST_TMUL,
        ST_RSQ,
        ST_RDIV,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [REQ_W-1:0]   req_reg, req_next;
    logic [W-1:0]       nv_reg, nv_next;
    logic [DUR_W-1:0]   dur_reg, dur_next;
    logic [W-1:0]       cur_reg, cur_next;
    logic [W-1:0]       tgt_reg, tgt_next;
    logic [W-1:0]       speed_reg, speed_next;
    logic [W-1:0]       accel_reg, accel_next;
    logic [W-1:0]       dist_reg, dist_next;
    logic               busy_reg, busy_next;
    logic               m_valid_reg, m_valid_next;
    logic [W-1:0]       m_data_reg, m_data_next;
    logic               m_flag_reg, m_flag_next;

    logic               tick_start, tt_start, div_start;
    vrmp_unit_status_t  sq_st, da_st, tt_st, dv_st;
    logic [2*W-1:0]     sq_prod, da_prod;
    logic [TT_W-1:0]    tt_prod;
    logic [W+1:0]       quot;

    logic signed [W:0]  cur_x, tgt_x, nv_x, spd_x, acc_x;
    logic signed [W:0]  step_dn, step_up, moved, dist_t, dist_r;
    logic [W:0]         spd_sum;
    logic signed [W:0]  spd_dif;
    logic [W-1:0]       spd_upd;

    assign cur_x = $signed({cur_reg[W-1], cur_reg});
    assign tgt_x = $signed({tgt_reg[W-1], tgt_reg});
    assign nv_x  = $signed({nv_reg[W-1], nv_reg});
    assign spd_x = $signed({1'b0, speed_reg});
    assign acc_x = $signed({1'b0, accel_reg});

    assign step_dn = cur_x - spd_x;
    assign step_up = cur_x + spd_x;

    always_comb begin
        if (cur_x > tgt_x) begin
            moved = (step_dn < tgt_x) ? tgt_x : step_dn;
        end else begin
            moved = (step_up > tgt_x) ? tgt_x : step_up;
        end
    end

    assign dist_t = (cur_x > tgt_x) ? (cur_x - tgt_x) : (tgt_x - cur_x);
    assign dist_r = (cur_x > nv_x) ? (cur_x - nv_x) : (nv_x - cur_x);

    assign spd_sum = {1'b0, speed_reg} + {1'b0, accel_reg};
    assign spd_dif = spd_x - acc_x;

    always_comb begin
        if (sq_prod < da_prod) begin
            if (spd_sum > {1'b0, V_MAX}) begin
                spd_upd = V_MAX;
            end else if (spd_sum < {1'b0, V_ONE}) begin
                spd_upd = V_ONE;
            end else begin
                spd_upd = spd_sum[W-1:0];
            end
        end else begin
            if (spd_dif < $signed({1'b0, V_ONE})) begin
                spd_upd = V_ONE;
            end else begin
                spd_upd = spd_dif[W-1:0];
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        nv_next      = nv_reg;
        dur_next     = dur_reg;
        cur_next     = cur_reg;
        tgt_next     = tgt_reg;
        speed_next   = speed_reg;
        accel_next   = accel_reg;
        dist_next    = dist_reg;
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_flag_next  = m_flag_reg;
        tick_start   = 1'b0;
        tt_start     = 1'b0;
        div_start    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_next   = s_tuser;
                    nv_next    = s_tdata[W-1:0];
                    dur_next   = s_tdata[W+DUR_W-1:W];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                busy_next  = 1'b0;
                state_next = ST_DONE;
                case (req_reg)
                    REQ_TICK: begin
                        if (cur_reg == tgt_reg) begin
                            speed_next = '0;
                        end else begin
                            busy_next  = 1'b1;
                            cur_next   = moved[W-1:0];
                            state_next = ST_TDIFF;
                        end
                    end
                    REQ_RETARGET: begin
                        tgt_next  = nv_reg;
                        dist_next = dist_r[W-1:0];
                        if (dur_reg == '0) begin
                            accel_next = V_MAX;
                        end else begin
                            tt_start   = 1'b1;
                            state_next = ST_RSQ;
                        end
                    end
                    REQ_JUMP: begin
                        cur_next = nv_reg;
                    end
                    default: begin
                        cur_next = cur_reg;
                    end
                endcase
            end
            ST_TDIFF: begin
                dist_next  = dist_t[W-1:0];
                tick_start = 1'b1;
                state_next = ST_TMUL;
            end
            ST_TMUL: begin
                if (sq_st.done) begin
                    speed_next = spd_upd;
                    state_next = ST_DONE;
                end
            end
            ST_RSQ: begin
                if (tt_st.done) begin
                    div_start  = 1'b1;
                    state_next = ST_RDIV;
                end
            end
            ST_RDIV: begin
                if (dv_st.done) begin
                    if (quot > {2'b00, V_MAX}) begin
                        accel_next = V_MAX;
                    end else if (quot < {2'b00, V_ONE}) begin
                        accel_next = V_ONE;
                    end else begin
                        accel_next = quot[W-1:0];
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = cur_reg;
                    m_flag_next  = busy_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cur_reg     <= '0;
            tgt_reg     <= '0;
            speed_reg   <= '0;
            accel_reg   <= V_ONE;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cur_reg     <= cur_next;
            tgt_reg     <= tgt_next;
            speed_reg   <= speed_next;
            accel_reg   <= accel_next;
        end
        req_reg    <= req_next;
        nv_reg     <= nv_next;
        dur_reg    <= dur_next;
        dist_reg   <= dist_next;
        busy_reg   <= busy_next;
        m_data_reg <= m_data_next;
        m_flag_reg <= m_flag_next;
    end

    // speed squared
    vrmp_serial_mul #(.A_W(W), .B_W(W)) u_mul_sq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (tick_start),
        .a       (speed_reg),
        .b       (speed_reg),
        .status  (sq_st),
        .prod    (sq_prod)
    );

    // distance times acceleration
    vrmp_serial_mul #(.A_W(W), .B_W(W)) u_mul_da (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (tick_start),
        .a       (dist_next),
        .b       (accel_reg),
        .status  (da_st),
        .prod    (da_prod)
    );

    // duration squared
    vrmp_serial_mul #(.A_W(DUR_W), .B_W(DUR_W)) u_mul_tt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (tt_start),
        .a       (dur_reg),
        .b       (dur_reg),
        .status  (tt_st),
        .prod    (tt_prod)
    );

    vrmp_serial_div #(.N_W(W + 2), .D_W(TT_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({dist_reg, 2'b00}),
        .divisor  (tt_prod),
        .status   (dv_st),
        .quotient (quot)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(m_data_reg);
    assign m_tuser  = m_flag_reg;

    a_idle_units: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !(sq_st.busy || da_st.busy || tt_st.busy || dv_st.busy))
        else $error("word accepted while an arithmetic unit is busy");

    a_accel_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        accel_reg >= V_ONE)
        else $error("acceleration below one");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("output word appeared outside the done state");

    a_mul_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TMUL && sq_st.done) |-> da_st.done)
        else $error("tick products finished out of step");

endmodule

// ===== test/tb.sv =====
// testbench for the motion profile block: directed, random and backpressure runs against a predictor
`timescale 1ns / 1ps

module tb;
    import vrmp_pkg::*;

    localparam int  VW          = 24;
    localparam int  FB          = 8;
    localparam int  S_W         = 40;
    localparam int  M_W         = 24;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam longint POS_MAX  = (64'sd1 <<< (VW - 1)) - 1;
    localparam longint ONE_Q    = 64'sd1 <<< FB;
    localparam int  SETTLE_CYC  = 60;
    localparam int  QUIET_LIMIT = 2000;
    localparam int  HOLD_CYC    = 300;
    localparam int  RAND_WORDS  = 400;

    typedef struct packed {
        logic [VW-1:0] pos;
        logic          moving;
    } profile_out_t;

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata  = '0;   // new_value, duration_ticks
    logic [REQ_W-1:0] s_tuser = '0;  // req_type
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;         // current_out
    logic           m_tuser;         // in_progress

    value_relaxation_motion_profile uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    longint pos_now, pos_goal, speed, accel;
    profile_out_t expected_q[$];

    int  fault_count   = 0;
    int  results_seen  = 0;
    int  words_sent    = 0;
    int  tick_count    = 0;
    int  retarget_count = 0;
    int  jump_count    = 0;
    int  unused_count  = 0;
    int  arrivals      = 0;
    int  quiet_cycles  = 0;
    bit  src_gaps_on   = 0;
    bit  sink_stalls_on = 0;
    bit  hold_request  = 0;

    function automatic longint gap(input longint a, input longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic profile_out_t advance_profile(input logic [REQ_W-1:0] kind,
                                                     input logic [VW-1:0] val,
                                                     input logic [15:0] ticks);
        profile_out_t res;
        longint span;
        longint quot;
        res.moving = 1'b0;
        if (kind == REQ_TICK) begin
            if (pos_now == pos_goal) begin
                speed = 0;
            end else begin
                res.moving = 1'b1;
                if (pos_now > pos_goal) begin
                    pos_now = pos_now - speed;
                    if (pos_now < pos_goal) pos_now = pos_goal;
                end else begin
                    pos_now = pos_now + speed;
                    if (pos_now > pos_goal) pos_now = pos_goal;
                end
                span = gap(pos_now, pos_goal);
                if (speed * speed < span * accel) begin
                    speed = speed + accel;
                    if (speed > POS_MAX) speed = POS_MAX;
                end else begin
                    speed = speed - accel;
                end
                if (speed < ONE_Q) speed = ONE_Q;
            end
        end else if (kind == REQ_RETARGET) begin
            pos_goal = longint'($signed(val));
            span = gap(pos_now, pos_goal);
            if (ticks == 16'd0) begin
                accel = POS_MAX;
            end else begin
                quot = (span * 4) / (longint'(ticks) * longint'(ticks));
                if (quot > POS_MAX) quot = POS_MAX;
                accel = (quot < ONE_Q) ? ONE_Q : quot;
            end
        end else if (kind == REQ_JUMP) begin
            pos_now = longint'($signed(val));
        end
        res.pos = pos_now[VW-1:0];
        return res;
    endfunction

    task automatic send_word(input logic [REQ_W-1:0] kind, input logic [VW-1:0] val,
                             input logic [15:0] ticks);
        profile_out_t exp_out;
        s_tvalid <= 1'b1;
        s_tdata  <= {ticks, val};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        exp_out = advance_profile(kind, val, ticks);
        expected_q.push_back(exp_out);
        words_sent++;
        case (kind)
            REQ_TICK: begin
                tick_count++;
                if (exp_out.moving && pos_now == pos_goal) arrivals++;
            end
            REQ_RETARGET: retarget_count++;
            REQ_JUMP:     jump_count++;
            default:      unused_count++;
        endcase
        if (src_gaps_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    task automatic tick_word();
        send_word(REQ_TICK, VW'($urandom), 16'($urandom));
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drain();
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    // receiver side: random stalls, plus one long hold on request
    initial begin
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYC) @(posedge aclk);
                hold_request = 0;
            end else if (sink_stalls_on && $urandom_range(0, 6) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        profile_out_t exp_out;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected word: value %h moving %b", m_tdata[VW-1:0], m_tuser);
            end else begin
                exp_out = expected_q.pop_front();
                if (m_tdata[VW-1:0] !== exp_out.pos || m_tuser !== exp_out.moving) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch at word %0d: expected value %h moving %b, got %h %b",
                                 results_seen, exp_out.pos, exp_out.moving,
                                 m_tdata[VW-1:0], m_tuser);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d words pending",
                         quiet_cycles, expected_q.size());
                $display("** value_relaxation_motion_profile: FAILED **");
                $finish;
            end
        end
    end

    task automatic test_directed();
        tick_word();
        send_word(REQ_UNUSED, 24'hFFFFFF, 16'hFFFF);
        send_word(REQ_JUMP, 24'h7FFFFF, 16'h0000);
        tick_word();
        send_word(REQ_RETARGET, 24'h800000, 16'd0);
        repeat (4) tick_word();
        send_word(REQ_RETARGET, 24'h000000, 16'hFFFF);
        tick_word();
        send_word(REQ_JUMP, 24'h800000, 16'hFFFF);
        send_word(REQ_RETARGET, 24'h7FFFFF, 16'd1);
        repeat (4) tick_word();
        send_word(REQ_UNUSED, 24'h000000, 16'h0000);
        send_word(REQ_JUMP, 24'h000100, 16'h0000);
        send_word(REQ_RETARGET, 24'h000100, 16'd0);
        repeat (2) tick_word();
        end_burst();
        wait_drain();
    endtask

    task automatic motion_run(input int quota);
        int goal_words;
        int steps;
        int choice;
        int scale;
        logic [VW-1:0] dest;
        logic [15:0]   dur;
        goal_words = words_sent + quota;
        while (words_sent < goal_words) begin
            choice = $urandom_range(0, 11);
            if (choice == 0) begin
                send_word(REQ_W'(REQ_TICK + $urandom_range(0, 3)), VW'($urandom),
                          16'($urandom));
            end else if (choice == 1) begin
                send_word(REQ_JUMP, VW'($urandom), 16'($urandom));
            end else begin
                scale = $urandom_range(4, 22);
                if ($urandom_range(0, 3) == 0)
                    dest = VW'($urandom);
                else if ($urandom_range(0, 1) == 0)
                    dest = pos_now[VW-1:0] + VW'($urandom_range(0, 1 << scale));
                else
                    dest = pos_now[VW-1:0] - VW'($urandom_range(0, 1 << scale));
                case ($urandom_range(0, 9))
                    0:       dur = 16'd0;
                    1:       dur = 16'($urandom);
                    default: dur = 16'($urandom_range(1, 24));
                endcase
                send_word(REQ_RETARGET, dest, dur);
                steps = 0;
                while (pos_now != pos_goal && steps < 64) begin
                    if ($urandom_range(0, 40) == 0)
                        send_word(REQ_RETARGET, VW'($urandom), 16'($urandom_range(0, 30)));
                    else if ($urandom_range(0, 60) == 0)
                        send_word(REQ_JUMP, VW'($urandom), 16'($urandom));
                    else
                        tick_word();
                    steps++;
                end
                repeat ($urandom_range(0, 2)) tick_word();
            end
        end
        end_burst();
    endtask

    task automatic test_random_idling();
        src_gaps_on    = 1;
        sink_stalls_on = 1;
        motion_run(RAND_WORDS * 6 / 10);
        wait_drain();
    endtask

    task automatic test_output_hold();
        src_gaps_on  = 0;
        hold_request = 1;
        send_word(REQ_RETARGET, pos_now[VW-1:0] + 24'h004000, 16'd8);
        repeat (11) tick_word();
        end_burst();
        wait_drain();
    endtask

    task automatic test_sender_pause();
        src_gaps_on = 1;
        send_word(REQ_JUMP, VW'($urandom), 16'($urandom));
        send_word(REQ_RETARGET, VW'($urandom), 16'd6);
        repeat (3) tick_word();
        end_burst();
        wait_drain();
        repeat (5) tick_word();
        end_burst();
        wait_drain();
    endtask

    task automatic test_back_to_back();
        src_gaps_on    = 0;
        sink_stalls_on = 0;
        motion_run(RAND_WORDS * 4 / 10);
        wait_drain();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        pos_now  = 0;
        pos_goal = 0;
        speed    = 0;
        accel    = ONE_Q;

        test_directed();
        test_random_idling();
        test_output_hold();
        test_sender_pause();
        test_back_to_back();

        repeat (SETTLE_CYC) @(posedge aclk);
        $display("covered %0d words: %0d ticks (%0d arrivals), %0d retargets, %0d jumps, %0d unused",
                 words_sent, tick_count, arrivals, retarget_count, jump_count, unused_count);
        $display("checked %0d result words with random stalls, a long output hold and a drain pause",
                 results_seen);
        if (fault_count == 0 && expected_q.size() == 0) begin
            $display("** value_relaxation_motion_profile: PASSED **");
        end else begin
            $display("** value_relaxation_motion_profile: FAILED **");
        end
        $finish;
    end

endmodule
